/* rtl/alr_pkg.sv */
// Shared types and constants for the audio loop recorder.
// Holds the request and response payload structs, command, mode, register and state codes.
// No dependencies.
`default_nettype none

package alr_pkg;

   localparam int MAX_LOOP_SAMPLES = 16777216;
   localparam int POS_BITS = $clog2(MAX_LOOP_SAMPLES);
   localparam int LEN_BITS = $clog2(MAX_LOOP_SAMPLES + 1);
   localparam int WGT_BITS = 17;
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic signed [16:0] MIX_K = 17'sd31719;
   localparam logic signed [33:0] MIX_ROUND = 34'sd16384;
   localparam logic [15:0] FADE_LENGTH_RESET = 16'd1000;
   localparam logic [14:0] DETECT_THRESHOLD_RESET = 15'd819;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_PRESS  = 2'd1,
      CMD_HOLD   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_WAIT   = 2'd1,
      MODE_RECORD = 2'd2,
      MODE_PLAY   = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FADE_LENGTH      = 2'd0,
      CSR_DETECT_THRESHOLD = 2'd1,
      CSR_DETECT_ENABLE    = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      S_READY,
      S_PROD,
      S_FREAD,
      S_FMUL,
      S_FDIV,
      S_FWRITE
   } state_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic signed [15:0]  sample_in;
      logic [15:0]         dry_wet;
   } req_type;

   typedef struct packed {
      logic signed [15:0]  sample_out;
      logic [1:0]          mode;
      logic                save_request;
      logic                clear_request;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/audio_loop_recorder.sv */
// Top level of the audio loop recorder: loop store, control, mixer and tail fade.
// Depends on alr_pkg.
//
// Every request yields one response. A request is taken while the loop store is read or
// written at the play position; the next cycle forms the two mixer products from the store
// data, and the response enters the output register once it is free. No new request is
// taken until the products of the last are formed (the store has a single port with a
// registered read), nor while the mixer register waits on a stalled output. The request
// that ends a take (second press, or the store running full) starts a fade of the loop tail
// that walks the store through the same port sample by sample (read, multiply, 16 steps of
// a bit-serial divider, write back), for min(fade_length, loop length) samples when the loop
// is longer than twice fade_length and for the whole loop otherwise. No request is taken
// during the fade; its response and configuration writes are handled as usual. The store
// needs no clearing after reset, as playback only reads samples recorded in the current take.
`default_nettype none

module audio_loop_recorder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  alr_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output alr_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [alr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [alr_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import alr_pkg::*;

   logic [15:0]               store_mem [MAX_LOOP_SAMPLES];
   logic signed [15:0]        mem_rd_ff;
   logic                      mem_we;
   logic [POS_BITS-1:0]       mem_addr;
   logic [15:0]               mem_wd;

   logic [15:0]               fade_len_ff;
   logic [14:0]               thresh_ff;
   logic                      det_en_ff;

   state_type                 state_ff, state_in;

   logic [POS_BITS-1:0]       pos_ff, pos_in;
   logic [LEN_BITS-1:0]       len_ff, len_in;
   logic [LEN_BITS-1:0]       count_ff, count_in;
   logic                      first_ff, first_in;
   logic                      rec_ff, rec_in;
   logic                      play_ff, play_in;
   logic                      wait_ff, wait_in;
   logic                      rst_ok_ff, rst_ok_in;
   logic                      have_last_ff, have_last_in;
   logic signed [15:0]        last_ff, last_in;
   logic                      fade_pend_ff, fade_pend_in;

   logic signed [15:0]        it_s_ff, it_s_in;
   logic [15:0]               it_g_ff, it_g_in;
   logic                      it_loop_ff, it_loop_in;
   logic                      it_raw_ff, it_raw_in;
   logic                      it_zero_ff, it_zero_in;
   rsp_type                   it_meta_ff, it_meta_in;

   logic                      mix_valid_ff, mix_valid_in;
   logic signed [32:0]        mix_a_ff, mix_a_in;
   logic signed [32:0]        mix_b_ff, mix_b_in;
   logic                      mix_raw_ff, mix_raw_in;
   logic                      mix_zero_ff, mix_zero_in;
   rsp_type                   mix_meta_ff, mix_meta_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   logic [POS_BITS-1:0]       fd_addr_ff, fd_addr_in;
   logic [WGT_BITS-1:0]       fd_w_ff, fd_w_in;
   logic [WGT_BITS-1:0]       fd_div_ff, fd_div_in;
   logic                      fd_neg_ff, fd_neg_in;
   logic [WGT_BITS-1:0]       div_rem_ff, div_rem_in;
   logic [15:0]               div_num_ff, div_num_in;
   logic [15:0]               div_quo_ff, div_quo_in;
   logic [DIV_CNT_BITS-1:0]   div_cnt_ff, div_cnt_in;

   logic                      mix_move;
   logic                      mix_free;
   logic                      accept;
   logic signed [16:0]        diff;
   logic [16:0]               abs_diff;
   logic                      det_hit;
   logic                      rec_now;
   logic                      fade_long;
   logic [WGT_BITS-1:0]       fade_amount;
   logic [15:0]               fade_value;

   assign mix_move = mix_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign mix_free = !mix_valid_ff || mix_move;
   assign accept   = req_valid && !req_stall;

   assign diff     = 17'(req_data.sample_in) - 17'(last_ff);
   assign abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
   assign det_hit  = wait_ff && have_last_ff && (abs_diff > {2'b00, thresh_ff});
   assign rec_now  = rec_ff || det_hit;

   assign fade_long   = 32'(len_ff) > 32'({fade_len_ff, 1'b0});
   assign fade_amount = fade_long ? WGT_BITS'(fade_len_ff) : WGT_BITS'(len_ff);
   assign fade_value  = fd_neg_ff ? 16'(-div_quo_ff) : div_quo_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wd;
      end
      mem_rd_ff <= store_mem[mem_addr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_READY: begin
            if (accept) begin
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            if (fade_pend_ff && (fade_amount != '0)) begin
               state_in = S_FREAD;
            end else begin
               state_in = S_READY;
            end
         end
         S_FREAD:  state_in = S_FMUL;
         S_FMUL:   state_in = S_FDIV;
         S_FDIV: begin
            if (div_cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = S_FWRITE;
            end
         end
         S_FWRITE: begin
            if (fd_w_ff == '0) begin
               state_in = S_READY;
            end else begin
               state_in = S_FREAD;
            end
         end
         default:  state_in = S_READY;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_addr  = pos_ff;
      mem_wd    = req_data.sample_in;
      case (state_ff)
         S_READY: begin
            req_stall = !mix_free;
            mem_we    = accept && (req_data.cmd == CMD_SAMPLE) && rec_now;
         end
         S_FREAD: begin
            mem_addr = fd_addr_ff;
         end
         S_FWRITE: begin
            mem_we   = 1'b1;
            mem_addr = fd_addr_ff;
            mem_wd   = fade_value;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      logic signed [33:0]      sum;
      logic signed [18:0]      scaled;
      logic signed [15:0]      loopv;
      logic signed [16:0]      gain;
      logic [LEN_BITS-1:0]     count_inc;
      logic [LEN_BITS-1:0]     pos_inc;
      logic [15:0]             mag;
      logic [32:0]             fprod;
      logic [WGT_BITS:0]       trial;
      logic                    ge;

      pos_in       = pos_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      rec_in       = rec_ff;
      play_in      = play_ff;
      wait_in      = wait_ff;
      rst_ok_in    = rst_ok_ff;
      have_last_in = have_last_ff;
      last_in      = last_ff;
      fade_pend_in = fade_pend_ff;
      it_s_in      = it_s_ff;
      it_g_in      = it_g_ff;
      it_loop_in   = it_loop_ff;
      it_raw_in    = it_raw_ff;
      it_zero_in   = it_zero_ff;
      it_meta_in   = it_meta_ff;
      mix_valid_in = mix_valid_ff;
      mix_a_in     = mix_a_ff;
      mix_b_in     = mix_b_ff;
      mix_raw_in   = mix_raw_ff;
      mix_zero_in  = mix_zero_ff;
      mix_meta_in  = mix_meta_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      fd_addr_in   = fd_addr_ff;
      fd_w_in      = fd_w_ff;
      fd_div_in    = fd_div_ff;
      fd_neg_in    = fd_neg_ff;
      div_rem_in   = div_rem_ff;
      div_num_in   = div_num_ff;
      div_quo_in   = div_quo_ff;
      div_cnt_in   = div_cnt_ff;

      count_inc = count_ff + LEN_BITS'(1);
      pos_inc   = LEN_BITS'(pos_ff) + LEN_BITS'(1);
      loopv     = it_loop_ff ? mem_rd_ff : 16'sd0;
      gain      = $signed({1'b0, it_g_ff});
      mag       = mem_rd_ff[15] ? 16'(-mem_rd_ff) : mem_rd_ff;
      fprod     = 33'(mag) * 33'(fd_w_ff);
      trial     = {div_rem_ff, div_num_ff[15]};
      ge        = trial >= {1'b0, fd_div_ff};

      sum    = 34'(mix_a_ff) + 34'(mix_b_ff) + MIX_ROUND;
      scaled = sum[33:15];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (mix_move) begin
         mix_valid_in = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = mix_meta_ff;
         if (mix_zero_ff) begin
            rsp_data_in.sample_out = '0;
         end else if (!mix_raw_ff) begin
            if (scaled > 19'sd32767) begin
               rsp_data_in.sample_out = 16'sh7FFF;
            end else if (scaled < -19'sd32768) begin
               rsp_data_in.sample_out = 16'sh8000;
            end else begin
               rsp_data_in.sample_out = scaled[15:0];
            end
         end
      end

      case (state_ff)
         S_READY: begin
            if (accept) begin
               it_s_in      = req_data.sample_in;
               it_g_in      = req_data.dry_wet;
               it_loop_in   = 1'b0;
               it_raw_in    = 1'b0;
               it_zero_in   = (req_data.cmd != CMD_SAMPLE);
               fade_pend_in = 1'b0;
               it_meta_in.sample_out    = req_data.sample_in;
               it_meta_in.save_request  = 1'b0;
               it_meta_in.clear_request = 1'b0;
               case (req_data.cmd)
                  CMD_SAMPLE: begin
                     rec_in       = rec_now;
                     play_in      = play_ff || det_hit;
                     wait_in      = wait_ff && !det_hit;
                     last_in      = req_data.sample_in;
                     have_last_in = 1'b1;
                     it_raw_in    = rec_now;
                     it_loop_in   = !rec_now && play_in;
                     if (rec_now) begin
                        count_in = count_inc;
                     end
                     if (rec_now && (count_inc == LEN_BITS'(MAX_LOOP_SAMPLES))) begin
                        // A take always starts at position zero, so a full store wraps to zero.
                        rec_in       = 1'b0;
                        first_in     = 1'b0;
                        rst_ok_in    = 1'b1;
                        len_in       = count_inc;
                        count_in     = '0;
                        pos_in       = '0;
                        fade_pend_in = 1'b1;
                        it_meta_in.save_request = 1'b1;
                     end else if (play_in) begin
                        pos_in = (pos_inc >= len_ff) ? '0 : pos_inc[POS_BITS-1:0];
                     end
                  end
                  CMD_PRESS: begin
                     if (first_ff) begin
                        if (rec_ff) begin
                           if (count_ff == '0) begin
                              rec_in  = 1'b0;
                              play_in = 1'b0;
                              pos_in  = '0;
                           end else begin
                              // The position equals the take length here, so it wraps to zero.
                              rec_in       = 1'b0;
                              first_in     = 1'b0;
                              rst_ok_in    = 1'b1;
                              len_in       = count_ff;
                              count_in     = '0;
                              pos_in       = '0;
                              fade_pend_in = 1'b1;
                              it_meta_in.save_request = 1'b1;
                           end
                        end else if (wait_ff) begin
                           wait_in = 1'b0;
                        end else if (det_en_ff) begin
                           wait_in = 1'b1;
                        end else begin
                           rec_in  = 1'b1;
                           play_in = 1'b1;
                        end
                     end else begin
                        play_in = !play_ff;
                     end
                  end
                  CMD_HOLD: begin
                     if (rst_ok_ff) begin
                        pos_in       = '0;
                        len_in       = LEN_BITS'(MAX_LOOP_SAMPLES);
                        count_in     = '0;
                        first_in     = 1'b1;
                        rec_in       = 1'b0;
                        play_in      = 1'b0;
                        wait_in      = 1'b0;
                        rst_ok_in    = 1'b0;
                        have_last_in = 1'b0;
                        last_in      = '0;
                        it_meta_in.clear_request = 1'b1;
                     end
                  end
                  default: begin
                     rec_in = rec_ff;
                  end
               endcase
               if (rec_in) begin
                  it_meta_in.mode = MODE_RECORD;
               end else if (play_in) begin
                  it_meta_in.mode = MODE_PLAY;
               end else if (wait_in) begin
                  it_meta_in.mode = MODE_WAIT;
               end else begin
                  it_meta_in.mode = MODE_IDLE;
               end
            end
         end
         S_PROD: begin
            mix_valid_in = 1'b1;
            mix_a_in     = loopv * gain;
            mix_b_in     = it_s_ff * (MIX_K - gain);
            mix_raw_in   = it_raw_ff;
            mix_zero_in  = it_zero_ff;
            mix_meta_in  = it_meta_ff;
            if (fade_pend_ff) begin
               fade_pend_in = 1'b0;
               fd_div_in    = fade_amount;
               fd_w_in      = fade_amount - WGT_BITS'(1);
               fd_addr_in   = POS_BITS'(32'(len_ff) - 32'(fade_amount));
            end
         end
         S_FMUL: begin
            fd_neg_in  = mem_rd_ff[15];
            div_rem_in = fprod[32:16];
            div_num_in = fprod[15:0];
            div_quo_in = '0;
            div_cnt_in = '0;
         end
         S_FDIV: begin
            div_rem_in = ge ? WGT_BITS'(trial - {1'b0, fd_div_ff}) : trial[WGT_BITS-1:0];
            div_quo_in = {div_quo_ff[14:0], ge};
            div_num_in = {div_num_ff[14:0], 1'b0};
            div_cnt_in = div_cnt_ff + DIV_CNT_BITS'(1);
         end
         S_FWRITE: begin
            if (fd_w_ff != '0) begin
               fd_addr_in = fd_addr_ff + POS_BITS'(1);
               fd_w_in    = fd_w_ff - WGT_BITS'(1);
            end
         end
         default: begin
            fd_neg_in = fd_neg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_READY;
         fade_len_ff  <= FADE_LENGTH_RESET;
         thresh_ff    <= DETECT_THRESHOLD_RESET;
         det_en_ff    <= 1'b1;
         pos_ff       <= '0;
         len_ff       <= LEN_BITS'(MAX_LOOP_SAMPLES);
         count_ff     <= '0;
         first_ff     <= 1'b1;
         rec_ff       <= 1'b0;
         play_ff      <= 1'b0;
         wait_ff      <= 1'b0;
         rst_ok_ff    <= 1'b0;
         have_last_ff <= 1'b0;
         last_ff      <= '0;
         fade_pend_ff <= 1'b0;
         mix_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         rec_ff       <= rec_in;
         play_ff      <= play_in;
         wait_ff      <= wait_in;
         rst_ok_ff    <= rst_ok_in;
         have_last_ff <= have_last_in;
         last_ff      <= last_in;
         fade_pend_ff <= fade_pend_in;
         mix_valid_ff <= mix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FADE_LENGTH:      fade_len_ff <= csr_wdata;
               CSR_DETECT_THRESHOLD: thresh_ff   <= csr_wdata[14:0];
               CSR_DETECT_ENABLE:    det_en_ff   <= csr_wdata[0];
               default:              fade_len_ff <= fade_len_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      it_s_in_reg : begin
         it_s_ff     <= it_s_in;
         it_g_ff     <= it_g_in;
         it_loop_ff  <= it_loop_in;
         it_raw_ff   <= it_raw_in;
         it_zero_ff  <= it_zero_in;
         it_meta_ff  <= it_meta_in;
         mix_a_ff    <= mix_a_in;
         mix_b_ff    <= mix_b_in;
         mix_raw_ff  <= mix_raw_in;
         mix_zero_ff <= mix_zero_in;
         mix_meta_ff <= mix_meta_in;
         rsp_data_ff <= rsp_data_in;
         fd_addr_ff  <= fd_addr_in;
         fd_w_ff     <= fd_w_in;
         fd_div_ff   <= fd_div_in;
         fd_neg_ff   <= fd_neg_in;
         div_rem_ff  <= div_rem_in;
         div_num_ff  <= div_num_in;
         div_quo_ff  <= div_quo_in;
         div_cnt_ff  <= div_cnt_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/alr_checker.sv */
// Port-level checks for the audio loop recorder, attached to the top level by a bind.
// Depends on alr_pkg and audio_loop_recorder.
`default_nettype none

module alr_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input alr_pkg::rsp_type  rsp_data
);
   import alr_pkg::*;

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or vanished");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.save_request |->
         rsp_data.mode == MODE_PLAY && !rsp_data.clear_request)
      else $error("completed loop does not continue playing");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.clear_request |->
         rsp_data.mode == MODE_IDLE && rsp_data.sample_out == '0)
      else $error("long-hold reset did not return to idle with silent output");

endmodule

bind audio_loop_recorder alr_checker u_alr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
